@@ rtl/tone_melody_sequencer_defines.svh @@
// Assertion macros shared by the tone melody sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TONE_MELODY_SEQUENCER_DEFINES_SVH
`define TONE_MELODY_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone_melody_sequencer: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone_melody_sequencer: next-cycle check failed");

`endif

@@ rtl/tms_pkg.sv @@
// Package for the tone melody sequencer: item types, command codes, states.
// No dependencies; used by tms_note_mem and tone_melody_sequencer.
`timescale 1ns / 1ps

package tms_pkg;

    localparam int NOTE_DEPTH_DEF = 16;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  note_index;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [4:0]  play_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic        tone_on;
        logic        is_playing;
        logic        melody_done;
    } t_out_item;

    // One note store entry: frequency in the upper half, duration below.
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] duration;
    } t_note;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUR,
        ST_FREQ,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/tms_note_mem.sv @@
// Note store: single write port, single read port with registered data.
// Depends on tms_pkg for the note entry type.
`timescale 1ns / 1ps

module tms_note_mem
    import tms_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
    localparam int AW = $clog2(NOTE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_note         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_note         o_rdata
);

    t_note r_mem [NOTE_DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tone_melody_sequencer.sv @@
// Tone melody sequencer top level: command decode, playback control, result register.
// Depends on tms_pkg, tms_note_mem and tone_melody_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "tone_melody_sequencer_defines.svh"

// The sequencer takes one command item at a time on the input channel: a
// one-millisecond tick, a note write, a playback start or a stop. Notes
// (frequency and duration) live in a note store of NOTE_DEPTH entries
// built as a synchronous memory with one read port and registered read
// data; there is no clearing pass after reset, and reading a note that
// was never written gives an undefined tone. Every item yields exactly one
// result item carrying the tone frequency, the tone enable, the playing
// flag and the done flag. An item that does not touch the note store
// (stop, write, a tick while idle, a start with a count of zero) goes
// from the idle state through the emit state into the output register;
// a start also passes through the frequency read state, a tick that stays
// on the current note or ends the melody through the duration read state,
// and a tick that moves on to the next note through both, duration first.
// These steps come from the note store read port: a tick reads the current
// note's duration, and a note change then reads the next note's frequency.
// The input channel is ready again as soon as the result is in the output
// register, so a new item is processed while the previous result waits to
// be taken; if that result is still unclaimed when the next one is ready,
// the sequencer waits.
module tone_melody_sequencer
    import tms_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Address width of the note store, width of the position and length
    // counters (they must reach NOTE_DEPTH itself), and a compare width that
    // also covers the five-bit play count.
    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int PW = $clog2(NOTE_DEPTH + 1);
    localparam int CW = (PW > 5) ? PW : 5;

    // Playback state.
    t_state        r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_len, n_len;
    logic [15:0]   r_elapsed, n_elapsed;
    logic          r_playing, n_playing;
    logic [15:0]   r_freq, n_freq;
    logic          r_done, n_done;

    // Output register.
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    // Note store port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_note         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_note         mem_rdata;

    // Helpers for the decode.
    logic          idx_ok;
    logic [CW-1:0] count_ext;
    logic [CW-1:0] count_sat;
    logic [15:0]   elapsed_inc;
    logic [PW-1:0] pos_inc;

    tms_note_mem #(
        .NOTE_DEPTH(NOTE_DEPTH)
    ) u_note_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // A write to an index past the end of the store is dropped, and a play
    // count larger than the store is clamped to the store depth.
    assign idx_ok      = (int'(i_in_item.note_index) < NOTE_DEPTH);
    assign count_ext   = CW'(i_in_item.play_count);
    assign count_sat   = (count_ext > CW'(NOTE_DEPTH)) ? CW'(NOTE_DEPTH) : count_ext;
    assign elapsed_inc = (r_elapsed != ELAPSED_MAX) ? (r_elapsed + 16'd1) : r_elapsed;
    assign pos_inc     = r_pos + PW'(1);

    assign mem_waddr = AW'(i_in_item.note_index);
    assign mem_wdata = '{freq: i_in_item.note_freq, duration: i_in_item.note_duration};

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_elapsed   = r_elapsed;
        n_playing   = r_playing;
        n_freq      = r_freq;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_raddr   = r_pos[AW-1:0];
        o_in_ready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_done = 1'b0;
                    case (i_in_item.cmd)
                        CMD_TICK: begin
                            // The current note's duration is read on every
                            // tick while playing, so a rewrite of that entry
                            // takes effect at once.
                            if (r_playing) begin
                                mem_raddr = r_pos[AW-1:0];
                                n_state   = ST_DUR;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        CMD_WRITE: begin
                            mem_we  = idx_ok;
                            n_state = ST_EMIT;
                        end
                        CMD_START: begin
                            if (i_in_item.play_count != 5'd0) begin
                                n_len     = PW'(count_sat);
                                n_pos     = '0;
                                n_elapsed = '0;
                                n_playing = 1'b1;
                                mem_raddr = '0;
                                n_state   = ST_FREQ;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                            n_playing = 1'b0;
                            n_freq    = '0;
                            n_state   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DUR: begin
                // At most one note ends per tick, even a note of zero length.
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= mem_rdata.duration) begin
                    n_pos = pos_inc;
                    if (pos_inc >= r_len) begin
                        n_playing = 1'b0;
                        n_freq    = '0;
                        n_done    = 1'b1;
                        n_state   = ST_EMIT;
                    end else begin
                        n_elapsed = '0;
                        mem_raddr = pos_inc[AW-1:0];
                        n_state   = ST_FREQ;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_FREQ: begin
                n_freq  = mem_rdata.freq;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.tone_freq   = r_freq;
                    n_out.tone_on     = r_playing && (r_freq != 16'd0);
                    n_out.is_playing  = r_playing;
                    n_out.melody_done = r_done;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_len       <= '0;
            r_elapsed   <= '0;
            r_playing   <= 1'b0;
            r_freq      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_elapsed   <= n_elapsed;
            r_playing   <= n_playing;
            r_freq      <= n_freq;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A tone is only ever driven while a melody plays.
    `TMS_ASSERT_IMP(a_tone_needs_play, i_clk, i_rst_n, r_out_valid && r_out.tone_on, r_out.is_playing)
    // The done flag marks the end of playback, never a playing result.
    `TMS_ASSERT_IMP(a_done_not_playing, i_clk, i_rst_n, r_out_valid && r_out.melody_done, !r_out.is_playing)
    // While playing, the position stays inside a non-empty melody.
    `TMS_ASSERT_IMP(a_pos_in_melody, i_clk, i_rst_n, r_playing, (r_pos < r_len) && (r_len != '0))
    // One item at a time: after an item is taken the input is not ready.
    `TMS_ASSERT_NXT(a_one_item_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

@@ tb/tone_melody_sequencer_tb.sv @@
// Self-checking testbench for the tone melody sequencer: directed table, then random melodies.
// Depends on tms_pkg and the tone_melody_sequencer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tone_melody_sequencer_tb;
    import tms_pkg::*;

    localparam int NOTES        = NOTE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SINK_HOLD    = 300;

    // One row of the directed table. Where typed is set, result holds the
    // expected result item; otherwise the predictor supplies it.
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item result;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // Predicted sequencer state.
    t_note       note_bank [NOTES];
    logic [15:0] note_written = '0;
    logic [4:0]  play_pos = '0;
    logic [4:0]  melody_len = '0;
    logic [15:0] elapsed = '0;
    logic        playing = 1'b0;
    logic [15:0] cur_freq = '0;

    t_out_item   pending_tones [$];
    t_dir_row    dir_rows [$];
    int          tone_errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          calm_tx = 1'b0;

    tone_melody_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a correct run ends far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Steps the predicted sequencer by one accepted item and returns the tone
    // state it should report. A tick adds one millisecond (saturating) and
    // moves on at most one note, even when the next note lasts 0 ms.
    function automatic t_out_item predict_tone(t_in_item it);
        t_out_item r;
        logic      done;
        done = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                if (playing) begin
                    if (elapsed != ELAPSED_MAX)
                        elapsed = elapsed + 16'd1;
                    if (elapsed >= note_bank[play_pos[3:0]].duration) begin
                        play_pos = play_pos + 5'd1;
                        if (play_pos >= melody_len) begin
                            playing  = 1'b0;
                            cur_freq = '0;
                            done     = 1'b1;
                        end else begin
                            elapsed  = '0;
                            cur_freq = note_bank[play_pos[3:0]].freq;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                note_bank[it.note_index] = '{freq: it.note_freq, duration: it.note_duration};
                note_written[it.note_index] = 1'b1;
            end
            CMD_START: begin
                // A count of zero is ignored; a count past the store saturates.
                if (it.play_count != 5'd0) begin
                    melody_len = (it.play_count > 5'(NOTES)) ? 5'(NOTES) : it.play_count;
                    play_pos   = '0;
                    elapsed    = '0;
                    playing    = 1'b1;
                    cur_freq   = note_bank[0].freq;
                end
            end
            default: begin
                playing  = 1'b0;
                cur_freq = '0;
            end
        endcase
        r.tone_freq   = cur_freq;
        r.tone_on     = playing && (cur_freq != 16'd0);
        r.is_playing  = playing;
        r.melody_done = done;
        return r;
    endfunction

    // Playback must never reach a note that was never written, so a start
    // count is cut back to the run of written entries from entry 0.
    function automatic logic [4:0] legal_count(logic [4:0] want);
        int prefix;
        int n;
        prefix = 0;
        while (prefix < NOTES && note_written[prefix])
            prefix++;
        n = (want > NOTES) ? NOTES : int'(want);
        if (want == 5'd0 || n <= prefix)
            return want;
        return 5'(prefix);
    endfunction

    function automatic t_dir_row mk_row(t_cmd c, logic [3:0] idx, logic [15:0] f,
                                        logic [15:0] d, logic [4:0] n,
                                        logic typed, t_out_item r);
        t_dir_row row;
        row.item          = '0;
        row.item.cmd      = c;
        row.item.note_index    = idx;
        row.item.note_freq     = f;
        row.item.note_duration = d;
        row.item.play_count    = n;
        row.typed         = typed;
        row.result        = r;
        return row;
    endfunction

    // Offers one item after a random gap and holds it until accepted. The
    // valid line stays high between back-to-back items.
    task automatic send_item(t_in_item it, logic typed, t_out_item typed_result);
        int        gap;
        t_out_item predicted;
        if ($urandom_range(0, 39) == 0)
            calm_tx = !calm_tx;
        gap = calm_tx ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        predicted = predict_tone(it);
        pending_tones.push_back(typed ? typed_result : predicted);
        items_sent++;
    endtask

    task automatic send_random(t_in_item it);
        send_item(it, 1'b0, '0);
    endtask

    // Noise: any command with every field random, a start count cut back by legal_count.
    task automatic send_noise();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        if (it.cmd == CMD_START)
            it.play_count = legal_count(it.play_count);
        send_random(it);
    endtask

    // A well-formed melody: write k notes, start, then tick through it with
    // some noise mixed in. Most notes are short so melodies finish often.
    task automatic play_random_melody(bit fill_store);
        t_in_item it;
        int       k;
        int       tick_budget;
        k = fill_store ? NOTES :
            ($urandom_range(0, 7) == 0) ? $urandom_range(1, NOTES) : $urandom_range(1, 5);
        for (int i = 0; i < k; i++) begin
            it               = t_in_item'({$urandom, $urandom});
            it.cmd           = CMD_WRITE;
            it.note_index    = 4'(i);
            if ($urandom_range(0, 7) == 0)
                it.note_freq = '0;
            it.note_duration = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 4));
            send_random(it);
        end
        it = t_in_item'({$urandom, $urandom});
        it.cmd = CMD_START;
        it.play_count = ($urandom_range(0, 3) == 0) ? legal_count(5'($urandom))
                                                     : legal_count(5'(k));
        send_random(it);
        tick_budget = $urandom_range(4, 40);
        for (int t = 0; t < tick_budget && playing; t++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end else begin
                it = t_in_item'({$urandom, $urandom});
                it.cmd = CMD_TICK;
                send_random(it);
            end
        end
        if (playing && $urandom_range(0, 1) == 0) begin
            it = t_in_item'({$urandom, $urandom});
            it.cmd = CMD_STOP;
            send_random(it);
        end
    endtask

    // Compares one accepted result item with the oldest expectation.
    function automatic void check_tone(t_out_item got);
        t_out_item want;
        results_seen++;
        if (pending_tones.size() == 0) begin
            tone_errors++;
            if (tone_errors <= 10)
                $display("Unexpected result item: freq %0d on %0b playing %0b done %0b",
                         got.tone_freq, got.tone_on, got.is_playing, got.melody_done);
            return;
        end
        want = pending_tones.pop_front();
        if (got.tone_freq != want.tone_freq || got.tone_on != want.tone_on ||
            got.is_playing != want.is_playing || got.melody_done != want.melody_done) begin
            tone_errors++;
            if (tone_errors <= 10)
                $display("Result %0d mismatch: expected freq %0d on %0b playing %0b done %0b, got freq %0d on %0b playing %0b done %0b",
                         results_seen, want.tone_freq, want.tone_on, want.is_playing,
                         want.melody_done, got.tone_freq, got.tone_on, got.is_playing,
                         got.melody_done);
        end
    endfunction

    // Result side: random ready gaps, stretches of constant ready, and one
    // long hold-off that backs the block up into its input channel.
    initial begin : result_sink
        int gap;
        bit calm;
        bit held;
        calm = 1'b0;
        held = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 19);
            if (!held && results_seen >= 400) begin
                held = 1'b1;
                gap  = SINK_HOLD;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid)
                @(posedge i_clk);
            check_tone(out_item);
        end
    end

    initial begin : stimulus
        t_out_item idle_tone;
        t_out_item top_tone;
        t_out_item done_tone;
        bit        paused;
        idle_tone = '0;
        top_tone  = '{tone_freq: 16'hFFFF, tone_on: 1'b1, is_playing: 1'b1, melody_done: 1'b0};
        done_tone = '{tone_freq: 16'd0, tone_on: 1'b0, is_playing: 1'b0, melody_done: 1'b1};
        paused    = 1'b0;

        // Directed table. Idle commands after reset report silence; then a
        // three-note melody covers the highest frequency, a silent note, a
        // zero-length note (one advance per tick) and the done flag. Later
        // rows write while playing, restart while playing, stop, and reach a
        // note with the longest duration.
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b1, idle_tone));
        dir_rows.push_back(mk_row(CMD_STOP,  4'd0,  16'd0,     16'd0,     5'd0, 1'b1, idle_tone));
        dir_rows.push_back(mk_row(CMD_START, 4'd0,  16'd0,     16'd0,     5'd0, 1'b1, idle_tone));
        dir_rows.push_back(mk_row(CMD_WRITE, 4'd0,  16'hFFFF,  16'd2,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_WRITE, 4'd1,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_WRITE, 4'd2,  16'd440,   16'd1,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_WRITE, 4'd3,  16'd1,     16'hFFFF,  5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_START, 4'd0,  16'd0,     16'd0,     5'd3, 1'b1, top_tone));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b1, done_tone));
        dir_rows.push_back(mk_row(CMD_START, 4'd0,  16'd0,     16'd0,     5'd4, 1'b1, top_tone));
        dir_rows.push_back(mk_row(CMD_WRITE, 4'd0,  16'd5,     16'd1,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_START, 4'd0,  16'd0,     16'd0,     5'd2, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_STOP,  4'd0,  16'd0,     16'd0,     5'd0, 1'b1, idle_tone));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b1, idle_tone));
        dir_rows.push_back(mk_row(CMD_START, 4'd0,  16'd0,     16'd0,     5'd4, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_TICK,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_STOP,  4'd0,  16'd0,     16'd0,     5'd0, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

        // The first random melody fills the whole store so that any start
        // count, including those past the store, is legal from then on.
        play_random_melody(1'b1);
        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            // Once mid-run the sender goes quiet until every result is back.
            if (!paused && items_sent >= 800) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_tones.size() != 0)
                    @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                play_random_melody(1'b0);
        end

        in_valid <= 1'b0;
        while (pending_tones.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tone_errors == 0 && pending_tones.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tms_pkg.sv
rtl/tms_note_mem.sv
rtl/tone_melody_sequencer.sv
tb/tone_melody_sequencer_tb.sv
